[rtl/sse_pkg.sv]
// Shared types, constants and character tables of the event stream parser.
package sse_pkg;

    localparam int MAX_EVENT_NAME_DEF = 32;
    localparam int CMD_DEPTH          = 4;
    localparam int MSG_LEN            = 7;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [2:0] EVENT_LEN    = 3'd5;
    localparam logic [2:0] DATA_KEY_LEN = 3'd4;
    localparam logic [2:0] MATCH_MAX    = 3'd7;

    localparam logic [1:0] CAND_EVENT = 2'b01;
    localparam logic [1:0] CAND_DATA  = 2'b10;
    localparam logic [1:0] CAND_BOTH  = 2'b11;

    typedef enum logic [2:0] {
        PH_START,
        PH_NAME,
        PH_EVENT,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_CLEAR,
        CMD_NBYTE,
        CMD_DISPATCH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] ch;
        logic       use_msg;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NWAIT,
        B_NAME,
        B_MSG,
        B_END
    } back_state_t;

    function automatic logic [7:0] event_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h65;
            3'd1:    c = 8'h76;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] data_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h64;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] msg_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h6D;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h61;
            3'd5:    c = 8'h67;
            3'd6:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/sse_event_stream_parser_core.sv]
// Top level of the server-sent-events stream parser.
// Usage:
//   Input channel (in_valid/in_ready, stream_byte) takes one raw stream word
//   per handshake. Output channel (out_valid/out_ready) gives result words:
//   kind, char_value, name_truncated and last_of_run, the last marking the
//   final result caused by one input word.
// A data word passes through the command queue and then the output register.
// Throughput: one input word per cycle while the command queue has room.
//   A dispatch leaves the idle state, then emits either the stored event
//   name, each byte fetched in a wait state (registered read of the name
//   memory), or "message" when no name was set, and then the end marker;
//   input stalls once the four-entry command queue fills behind it.
// Reset: rst_n clears parser state, the queue and the output register; the
//   name memory itself is not cleared and is only read up to the stored
//   length.
// Receiver stall: the output register holds its word while out_ready is low;
//   the sequencer and then the queue back up, and in_ready drops when the
//   queue is full.
module sse_event_stream_parser_core
    import sse_pkg::*;
#(
    parameter int MAX_EVENT_NAME = MAX_EVENT_NAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] stream_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] char_value,
    output logic       name_truncated,
    output logic       last_of_run
);

    logic cmd_full;
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_pop;
    logic cmd_valid;
    cmd_t cmd_head;

    sse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd_data    (cmd_in)
    );

    sse_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .head      (cmd_head)
    );

    sse_back #(
        .MAX_EVENT_NAME (MAX_EVENT_NAME)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd_head),
        .cmd_pop        (cmd_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .char_value     (char_value),
        .name_truncated (name_truncated),
        .last_of_run    (last_of_run)
    );

endmodule

[rtl/sse_front.sv]
// Line parser: classifies each input word and issues commands to the back end.
module sse_front
    import sse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] stream_byte,
    input  logic       cmd_full,
    output logic       cmd_push,
    output cmd_t       cmd_data
);

    phase_t     phase_reg, phase_next;
    logic [2:0] match_reg, match_next;
    logic [1:0] cand_reg, cand_next;
    logic       skip_reg, skip_next;
    logic       after_cr_reg, after_cr_next;
    logic       held_nl_reg, held_nl_next;
    logic       has_data_reg, has_data_next;
    logic       name_set_reg, name_set_next;

    logic       accept;
    logic       emit;
    cmd_t       cmd;

    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;
    assign cmd_push = accept && emit;
    assign cmd_data = cmd;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            match_reg    <= '0;
            cand_reg     <= CAND_BOTH;
            skip_reg     <= 1'b0;
            after_cr_reg <= 1'b0;
            held_nl_reg  <= 1'b0;
            has_data_reg <= 1'b0;
            name_set_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            match_reg    <= match_next;
            cand_reg     <= cand_next;
            skip_reg     <= skip_next;
            after_cr_reg <= after_cr_next;
            held_nl_reg  <= held_nl_next;
            has_data_reg <= has_data_next;
            name_set_reg <= name_set_next;
        end
    end

    always_comb
    begin
        logic [2:0] m;
        logic [1:0] cd;
        logic       in_name;
        phase_next    = phase_reg;
        match_next    = match_reg;
        cand_next     = cand_reg;
        skip_next     = skip_reg;
        after_cr_next = after_cr_reg;
        held_nl_next  = held_nl_reg;
        has_data_next = has_data_reg;
        name_set_next = name_set_reg;
        emit          = 1'b0;
        cmd.op        = CMD_DATA;
        cmd.ch        = stream_byte;
        cmd.use_msg   = 1'b0;
        m             = match_reg;
        cd            = cand_reg;
        in_name       = 1'b0;

        if (stream_byte == CH_LF && after_cr_reg)
        begin
            after_cr_next = 1'b0;
        end
        else if (stream_byte == CH_LF || stream_byte == CH_CR)
        begin
            after_cr_next = (stream_byte == CH_CR);
            if (phase_reg == PH_START)
            begin
                if (has_data_reg || name_set_reg)
                begin
                    emit          = 1'b1;
                    cmd.op        = CMD_DISPATCH;
                    cmd.use_msg   = !name_set_reg;
                    name_set_next = 1'b0;
                    has_data_next = 1'b0;
                    held_nl_next  = 1'b0;
                end
            end
            else if (phase_reg == PH_DATA)
            begin
                held_nl_next = 1'b1;
            end
            phase_next = PH_START;
            match_next = '0;
            cand_next  = CAND_BOTH;
            skip_next  = 1'b0;
        end
        else
        begin
            after_cr_next = 1'b0;
            unique case (phase_reg)
                PH_START:
                begin
                    if (stream_byte == CH_COLON)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_NAME;
                        m          = '0;
                        cd         = CAND_BOTH;
                        match_next = '0;
                        cand_next  = CAND_BOTH;
                        in_name    = 1'b1;
                    end
                end
                PH_NAME:
                begin
                    in_name = 1'b1;
                end
                PH_EVENT:
                begin
                    skip_next = 1'b0;
                    if (!(skip_reg && stream_byte == CH_SPACE))
                    begin
                        emit   = 1'b1;
                        cmd.op = CMD_NBYTE;
                    end
                end
                PH_DATA:
                begin
                    skip_next = 1'b0;
                    if (!(skip_reg && stream_byte == CH_SPACE))
                    begin
                        emit   = 1'b1;
                        cmd.op = CMD_DATA;
                    end
                end
                default:
                begin
                end
            endcase

            if (in_name)
            begin
                if (stream_byte == CH_COLON)
                begin
                    if ((cd & CAND_EVENT) != 2'b00 && m == EVENT_LEN)
                    begin
                        phase_next    = PH_EVENT;
                        name_set_next = 1'b1;
                        skip_next     = 1'b1;
                        emit          = 1'b1;
                        cmd.op        = CMD_CLEAR;
                    end
                    else if ((cd & CAND_DATA) != 2'b00 && m == DATA_KEY_LEN)
                    begin
                        phase_next    = PH_DATA;
                        has_data_next = 1'b1;
                        skip_next     = 1'b1;
                        if (held_nl_reg)
                        begin
                            emit         = 1'b1;
                            cmd.op       = CMD_DATA;
                            cmd.ch       = CH_LF;
                            held_nl_next = 1'b0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else
                begin
                    if ((cd & CAND_EVENT) != 2'b00 &&
                        !(m < EVENT_LEN && event_char(m) == stream_byte))
                        cd = cd & ~CAND_EVENT;
                    if ((cd & CAND_DATA) != 2'b00 &&
                        !(m < DATA_KEY_LEN && data_char(m) == stream_byte))
                        cd = cd & ~CAND_DATA;
                    cand_next  = cd;
                    match_next = (m < MATCH_MAX) ? m + 3'd1 : m;
                    phase_next = (cd == 2'b00) ? PH_SKIP : PH_NAME;
                end
            end
        end
    end

endmodule

[rtl/sse_cmd_fifo.sv]
// Short command queue between the line parser and the result sequencer.
module sse_cmd_fifo
    import sse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    localparam int AW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    cmd_t          slot_reg [CMD_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? AW'(wr_ptr_reg + AW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? AW'(rd_ptr_reg + AW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/sse_back.sv]
// Result sequencer: name store, dispatch emission and the output register.
module sse_back
    import sse_pkg::*;
#(
    parameter int MAX_EVENT_NAME = MAX_EVENT_NAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] char_value,
    output logic       name_truncated,
    output logic       last_of_run
);

    localparam int IW = $clog2(MAX_EVENT_NAME);
    localparam int LW = $clog2(MAX_EVENT_NAME + 1);

    logic [7:0]    name_mem [MAX_EVENT_NAME];
    logic [7:0]    rd_data_reg;

    back_state_t   state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic          ov_reg, ov_next;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    ch_reg, ch_next;
    logic          trunc_reg, trunc_next;
    logic          last_reg, last_next;

    logic          can_load;
    logic          wr_en;
    logic [IW-1:0] wr_addr;

    assign can_load       = !ov_reg || out_ready;
    assign out_valid      = ov_reg;
    assign kind           = kind_reg;
    assign char_value     = ch_reg;
    assign name_truncated = trunc_reg;
    assign last_of_run    = last_reg;
    assign wr_addr        = len_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk) begin
        kind_reg  <= kind_next;
        ch_reg    <= ch_next;
        trunc_reg <= trunc_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk) begin
        if (wr_en)
            name_mem[wr_addr] <= cmd.ch;
        rd_data_reg <= name_mem[idx_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !out_ready;
        kind_next  = kind_reg;
        ch_next    = ch_reg;
        trunc_next = trunc_reg;
        last_next  = last_reg;
        cmd_pop    = 1'b0;
        wr_en      = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid && can_load)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        CMD_DATA:
                        begin
                            ov_next    = 1'b1;
                            kind_next  = KIND_DATA;
                            ch_next    = cmd.ch;
                            trunc_next = 1'b0;
                            last_next  = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            len_next = '0;
                            ovf_next = 1'b0;
                        end
                        CMD_NBYTE:
                        begin
                            if (len_reg < LW'(MAX_EVENT_NAME))
                            begin
                                wr_en    = 1'b1;
                                len_next = len_reg + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_DISPATCH:
                        begin
                            idx_next = '0;
                            if (cmd.use_msg)
                                state_next = B_MSG;
                            else if (len_reg == '0)
                                state_next = B_END;
                            else
                                state_next = B_NWAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_NWAIT:
            begin
                state_next = B_NAME;
            end
            B_NAME:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_NAME;
                    ch_next    = rd_data_reg;
                    trunc_next = 1'b0;
                    last_next  = 1'b0;
                    idx_next   = idx_reg + IW'(1);
                    if (LW'(idx_reg) + LW'(1) == len_reg)
                        state_next = B_END;
                    else
                        state_next = B_NWAIT;
                end
            end
            B_MSG:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_NAME;
                    ch_next    = msg_char(idx_reg[2:0]);
                    trunc_next = 1'b0;
                    last_next  = 1'b0;
                    idx_next   = idx_reg + IW'(1);
                    if (idx_reg == IW'(MSG_LEN - 1))
                        state_next = B_END;
                end
            end
            B_END:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    kind_next  = KIND_END;
                    ch_next    = 8'h00;
                    trunc_next = ovf_reg;
                    last_next  = 1'b1;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_EVENT_NAME))
        else $error("name length beyond store");

    a_name_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_NAME || state_reg == B_NWAIT) |-> (LW'(idx_reg) < len_reg))
        else $error("name read index past stored length");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_END && can_load) |=>
            (len_reg == '0 && !ovf_reg && ov_reg && kind_reg == KIND_END && last_reg))
        else $error("end marker did not clear the name store state");

endmodule
